[rtl/gbnms_pkg.sv]
// ----------------------------------------------------------------------------
// gbnms_pkg
// Types and constants shared by the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbnms_pkg;

	localparam int COORD_BITS = 16;
	localparam int SCORE_BITS = 16;
	localparam int KIDX_BITS  = 6;
	localparam int THR_BITS   = 17;
	localparam int KEEP_BITS  = 7;
	localparam int CFGI_BITS  = 2;

	localparam logic [CFGI_BITS-1:0] REG_IOU_THRESHOLD = 2'd0;
	localparam logic [CFGI_BITS-1:0] REG_MAX_KEEP      = 2'd1;

	localparam logic [THR_BITS-1:0]  THR_RESET  = 17'd45875;
	localparam logic [KEEP_BITS-1:0] KEEP_RESET = 7'd0;

	// Areas reach 2^32, unions 2^33.
	localparam int AREA_BITS = 2 * COORD_BITS + 1;
	localparam int UNI_BITS  = 2 * COORD_BITS + 2;
	localparam int RHS_BITS  = THR_BITS + UNI_BITS;

	typedef struct packed {
		logic [COORD_BITS-1:0] box_x1;
		logic [COORD_BITS-1:0] box_y1;
		logic [COORD_BITS-1:0] box_x2;
		logic [COORD_BITS-1:0] box_y2;
		logic [SCORE_BITS-1:0] box_score;
		logic                  box_last;
	} box_in_t;

	typedef struct packed {
		logic [KIDX_BITS-1:0] kept_index;
		logic                 kept_last;
	} kept_out_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
		logic [COORD_BITS-1:0] x2;
		logic [COORD_BITS-1:0] y2;
		logic [SCORE_BITS-1:0] score;
		logic [AREA_BITS-1:0]  area;
	} box_entry_t;

	typedef struct packed {
		logic visited;
		logic suppressed;
	} box_flags_t;

	function automatic logic [COORD_BITS:0] span(input logic [COORD_BITS-1:0] lo,
			input logic [COORD_BITS-1:0] hi);
		if (hi >= lo) begin
			return {1'b0, hi} - {1'b0, lo} + {{COORD_BITS{1'b0}}, 1'b1};
		end
		return '0;
	endfunction

endpackage

[rtl/greedy_box_nms_with_limit_top.sv]
// ----------------------------------------------------------------------------
// greedy_box_nms_with_limit_top
// Greedy non-maximum suppression over one set of boxes, with a keep limit.
// ----------------------------------------------------------------------------
// Boxes arrive on the input channel one transaction per cycle while the block
// is idle; each of the first MAX_BOXES is written to the box memory at its
// load position. The transaction that carries box_last starts the greedy
// pass, and in_ready stays low until the last kept index of the set has
// entered the output register. The pass works out of one box memory and one
// flag memory, both read through a registered port. Each visit scans all N
// stored boxes for the highest unvisited score, marks the winner and, for a
// kept box, streams all N boxes through a six-stage overlap pipeline that
// writes the suppressed flags back. The final sweep then checks the boxes
// one at a time in load order and emits the indices of those that were kept.
// Results leave through an output register; when the receiver stalls, the
// sweep waits on that register and nothing is lost. Reset returns the
// thresholds to their defaults and empties the set; the memories need no
// clearing, as flags are written as each box is loaded. Configuration writes
// are accepted on the cfg channel only while the block is idle, so a pass
// always runs with the settings that held when it started.
// ----------------------------------------------------------------------------
module greedy_box_nms_with_limit_top #(
	parameter int MAX_BOXES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  gbnms_pkg::box_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output gbnms_pkg::kept_out_t                out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gbnms_pkg::CFGI_BITS-1:0]     cfg_index,
	input  logic [gbnms_pkg::THR_BITS-1:0]      cfg_data
);

	localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = IW + 1;
	localparam int KW = (CW > gbnms_pkg::KEEP_BITS) ? CW : gbnms_pkg::KEEP_BITS;
	localparam int XW = gbnms_pkg::COORD_BITS;
	localparam int AW = gbnms_pkg::AREA_BITS;
	localparam int UW = gbnms_pkg::UNI_BITS;
	localparam int RW = gbnms_pkg::RHS_BITS;
	localparam int LW = AW + 16;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SRCH = 7'b0000010,
		ST_MARK = 7'b0000100,
		ST_SUPP = 7'b0001000,
		ST_ORD  = 7'b0010000,
		ST_OCHK = 7'b0100000,
		ST_OFIN = 7'b1000000
	} state_t;

	state_t state_q;

	gbnms_pkg::box_entry_t box_mem [MAX_BOXES];
	gbnms_pkg::box_flags_t flag_mem [MAX_BOXES];
	gbnms_pkg::box_entry_t rd_box_q;
	gbnms_pkg::box_flags_t rd_flag_q;

	logic [gbnms_pkg::THR_BITS-1:0]  thr_q;
	logic [gbnms_pkg::KEEP_BITS-1:0] keep_q;

	logic [CW-1:0] load_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] kept_q;
	logic          limit_q;

	// scan pipeline
	logic          v_s1;
	logic [IW-1:0] k_s1;

	// best box of the current visit
	logic                  found_q;
	logic [IW-1:0]         best_idx_q;
	logic                  best_sup_q;
	gbnms_pkg::box_entry_t best_q;

	// overlap pipeline
	logic          v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [IW-1:0] k_s2, k_s3, k_s4, k_s5, k_s6;
	logic [XW-1:0] x1_s2, y1_s2, x2_s2, y2_s2;
	logic [AW-1:0] area_s2, area_s3, area_s4;
	logic [XW:0]   w_s3, h_s3;
	logic [AW-1:0] inter_s4, inter_s5, inter_s6;
	logic [UW-1:0] uni_s5;
	logic [RW-1:0] rhs_s6;

	// output sweep
	logic          pend_v_q;
	logic [IW-1:0] pend_q;
	logic          out_valid_q;
	gbnms_pkg::kept_out_t out_data_q;

	logic                  in_acc;
	logic                  slot_free;
	logic                  emit;
	logic                  issue;
	logic [IW-1:0]         rd_addr;
	gbnms_pkg::box_entry_t new_box;
	logic                  mem_we;
	logic [IW-1:0]         flag_wa;
	logic                  flag_we;
	gbnms_pkg::box_flags_t flag_wd;
	logic [AW-1:0]         new_area;
	logic [XW:0]           w_in, h_in;
	logic [2*XW+1:0]       area_prod;
	logic [2*XW+1:0]       inter_prod;
	logic [UW-1:0]         uni_calc;
	logic [RW-1:0]         rhs_calc;
	logic [LW-1:0]         lhs_s6;
	logic                  hit_s6;
	logic [KW-1:0]         kept_next;
	logic [IW+5:0]         pend_ext;
	logic [IW+5:0]         kidx_ext;
	logic                  scan_done;
	logic                  supp_done;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A held-back kept index moves to the output register.
	assign emit = slot_free && pend_v_q
		&& (((state_q == ST_OCHK) && !rd_flag_q.suppressed) || (state_q == ST_OFIN));

	assign issue   = ((state_q == ST_SRCH) || (state_q == ST_SUPP)) && (k_q < load_q);
	assign rd_addr = k_q[IW-1:0];

	assign w_in      = gbnms_pkg::span(in_data.box_x1, in_data.box_x2);
	assign h_in      = gbnms_pkg::span(in_data.box_y1, in_data.box_y2);
	assign area_prod = w_in * h_in;
	assign new_area  = area_prod[AW-1:0];

	always_comb begin
		new_box.x1    = in_data.box_x1;
		new_box.y1    = in_data.box_y1;
		new_box.x2    = in_data.box_x2;
		new_box.y2    = in_data.box_y2;
		new_box.score = in_data.box_score;
		new_box.area  = new_area;
	end

	assign mem_we     = in_acc && (load_q < CW'(MAX_BOXES));
	assign inter_prod = w_s3 * h_s3;
	assign uni_calc   = UW'(best_q.area) + UW'(area_s4) - UW'(inter_s4);
	assign rhs_calc   = RW'(thr_q) * RW'(uni_s5);
	assign lhs_s6     = {inter_s6, 16'b0};
	assign hit_s6     = (RW'(lhs_s6) >= rhs_s6);
	assign kept_next  = KW'(kept_q) + KW'(1);
	assign pend_ext   = {6'b0, pend_q};
	assign kidx_ext   = pend_ext;
	assign scan_done  = (k_q >= load_q) && !v_s1;
	assign supp_done  = scan_done && !v_s2 && !v_s3 && !v_s4 && !v_s5 && !v_s6;

	// Flag write port: loading clears, marking sets visited (and suppressed for
	// a box not kept); overlap sets suppressed on unvisited, unsuppressed hits.
	always_comb begin
		flag_we = 1'b0;
		flag_wa = '0;
		flag_wd = '0;
		case (state_q)
			ST_IDLE: begin
				flag_we = mem_we;
				flag_wa = load_q[IW-1:0];
			end
			ST_MARK: begin
				flag_we            = 1'b1;
				flag_wa            = best_idx_q;
				flag_wd.visited    = 1'b1;
				flag_wd.suppressed = best_sup_q || limit_q;
			end
			ST_SUPP: begin
				flag_we            = v_s6 && hit_s6;
				flag_wa            = k_s6;
				flag_wd.suppressed = 1'b1;
			end
			default: begin
				flag_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			box_mem[load_q[IW-1:0]] <= new_box;
		end
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
		rd_box_q  <= box_mem[rd_addr];
		rd_flag_q <= flag_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= gbnms_pkg::THR_RESET;
			keep_q <= gbnms_pkg::KEEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == gbnms_pkg::REG_IOU_THRESHOLD) begin
				thr_q <= cfg_data;
			end else if (cfg_index == gbnms_pkg::REG_MAX_KEEP) begin
				keep_q <= cfg_data[gbnms_pkg::KEEP_BITS-1:0];
			end
		end
	end

	// Overlap pipeline; the eligibility test rides in the valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && (state_q == ST_SUPP) && !rd_flag_q.visited
				&& !rd_flag_q.suppressed;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		k_s1     <= rd_addr;
		k_s2     <= k_s1;
		x1_s2    <= (rd_box_q.x1 > best_q.x1) ? rd_box_q.x1 : best_q.x1;
		y1_s2    <= (rd_box_q.y1 > best_q.y1) ? rd_box_q.y1 : best_q.y1;
		x2_s2    <= (rd_box_q.x2 < best_q.x2) ? rd_box_q.x2 : best_q.x2;
		y2_s2    <= (rd_box_q.y2 < best_q.y2) ? rd_box_q.y2 : best_q.y2;
		area_s2  <= rd_box_q.area;
		k_s3     <= k_s2;
		w_s3     <= gbnms_pkg::span(x1_s2, x2_s2);
		h_s3     <= gbnms_pkg::span(y1_s2, y2_s2);
		area_s3  <= area_s2;
		k_s4     <= k_s3;
		inter_s4 <= inter_prod[AW-1:0];
		area_s4  <= area_s3;
		k_s5     <= k_s4;
		inter_s5 <= inter_s4;
		uni_s5   <= uni_calc;
		k_s6     <= k_s5;
		inter_s6 <= inter_s5;
		rhs_s6   <= rhs_calc;
	end

	// Best box tracking during the search scan.
	always_ff @(posedge clk) begin
		if ((state_q == ST_SRCH) && v_s1 && !rd_flag_q.visited
				&& (!found_q || (rd_box_q.score > best_q.score))) begin
			best_q     <= rd_box_q;
			best_idx_q <= k_s1;
			best_sup_q <= rd_flag_q.suppressed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			load_q      <= '0;
			k_q         <= '0;
			kept_q      <= '0;
			limit_q     <= 1'b0;
			found_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
			if (issue) begin
				k_q <= k_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (mem_we) begin
							load_q <= load_q + CW'(1);
						end
						if (in_data.box_last) begin
							state_q <= ST_SRCH;
							k_q     <= '0;
							found_q <= 1'b0;
							kept_q  <= '0;
							limit_q <= 1'b0;
						end
					end
				end
				ST_SRCH: begin
					if (v_s1 && !rd_flag_q.visited) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						if (found_q) begin
							state_q <= ST_MARK;
						end else begin
							state_q  <= ST_ORD;
							k_q      <= '0;
							pend_v_q <= 1'b0;
						end
					end
				end
				ST_MARK: begin
					k_q     <= '0;
					found_q <= 1'b0;
					if (best_sup_q || limit_q) begin
						state_q <= ST_SRCH;
					end else begin
						kept_q <= kept_next[CW-1:0];
						if ((keep_q != '0) && (kept_next >= KW'(keep_q))) begin
							limit_q <= 1'b1;
							state_q <= ST_SRCH;
						end else begin
							state_q <= ST_SUPP;
						end
					end
				end
				ST_SUPP: begin
					if (supp_done) begin
						state_q <= ST_SRCH;
						k_q     <= '0;
						found_q <= 1'b0;
					end
				end
				ST_ORD: begin
					if (k_q >= load_q) begin
						state_q <= ST_OFIN;
					end else begin
						state_q <= ST_OCHK;
					end
				end
				ST_OCHK: begin
					// A kept index is held back until the next one is found,
					// so that the final one can carry kept_last.
					if (rd_flag_q.suppressed) begin
						k_q     <= k_q + CW'(1);
						state_q <= ST_ORD;
					end else if (slot_free) begin
						if (pend_v_q) begin
							out_data_q.kept_index <= kidx_ext[5:0];
							out_data_q.kept_last  <= 1'b0;
						end
						pend_v_q <= 1'b1;
						pend_q   <= k_q[IW-1:0];
						k_q      <= k_q + CW'(1);
						state_q  <= ST_ORD;
					end
				end
				ST_OFIN: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
						load_q  <= '0;
					end else if (slot_free) begin
						out_data_q.kept_index <= kidx_ext[5:0];
						out_data_q.kept_last  <= 1'b1;
						pend_v_q              <= 1'b0;
						state_q               <= ST_IDLE;
						load_q                <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
